// ----- rtl/isqrt_pkg.sv -----
package isqrt_pkg;

	// Datapath width; bit WIDTH-1 of the argument is its sign.
	localparam int WIDTH = 32;
	localparam int N_W = 32;
	localparam int ROOT_OUT_W = 16;

	// Root digits, and the radicand padded to an even number of bits.
	localparam int HALF = (WIDTH + 1) / 2;
	localparam int PAD_W = 2 * HALF;
	// The partial remainder never exceeds twice the partial root.
	localparam int REM_W = HALF + 1;
	localparam int WORK_W = REM_W + 2;
	localparam int SUM_W = HALF + 1;
	localparam int ROOT_EXT_W = (SUM_W > ROOT_OUT_W) ? SUM_W : ROOT_OUT_W;
	localparam int CNT_W = (HALF > 1) ? $clog2(HALF) : 1;
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(HALF - 1);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_RUN   = 3'b010,
		S_ROUND = 3'b100
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
	} ctrl_t;

endpackage

// ----- rtl/integer_square_root_core.sv -----
// Integer square root, one root bit per cycle. An item is taken, then the remainder/root
// unit steps once per root bit (16 for the 32-bit datapath) while the radicand shift
// register feeds it two bits at a time, and a round state applies the round-up and loads
// the output register as soon as that register is free. The next item is taken in the
// cycle that loads the output register, so items run back to back. A negative argument
// skips the root steps and gives root 0 with neg_error set when the round state loads
// the output register. With round_up set, a nonzero final remainder raises the floor by
// one; zero gives zero either way.
module integer_square_root_core
	import isqrt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic signed [N_W-1:0] n,
	input  logic                  round_up,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [ROOT_OUT_W-1:0] root,
	output logic                  neg_error
);

	state_t                  state_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    neg_q;
	logic                    up_q;
	logic                    out_valid_q;
	logic [ROOT_OUT_W-1:0]   root_q;
	logic                    neg_error_q;

	logic signed [WIDTH-1:0] arg;
	logic                    arg_neg;
	logic [PAD_W-1:0]        radicand;
	logic                    accept;
	logic                    out_free;
	logic                    finish;
	ctrl_t                   ctrl;
	logic [1:0]              pair;
	logic [HALF-1:0]         step_root;
	logic                    rem_nz;
	logic [SUM_W-1:0]        rounded;
	logic [ROOT_EXT_W-1:0]   rounded_ext;

	assign arg      = WIDTH'(n);
	assign arg_neg  = arg[WIDTH-1];
	assign radicand = PAD_W'(arg[WIDTH-2:0]);

	assign out_free = !out_valid_q || out_ready;
	assign finish   = (state_q == S_ROUND) && out_free;
	assign in_ready = (state_q == S_IDLE) || finish;
	assign accept   = in_valid && in_ready;

	assign ctrl.load = accept;
	assign ctrl.step = (state_q == S_RUN);

	isqrt_shreg u_shreg (
		.clk      (clk),
		.ctrl     (ctrl),
		.radicand (radicand),
		.pair     (pair)
	);

	isqrt_step u_step (
		.clk    (clk),
		.ctrl   (ctrl),
		.pair   (pair),
		.root   (step_root),
		.rem_nz (rem_nz)
	);

	assign rounded     = SUM_W'(step_root) + SUM_W'(up_q && rem_nz);
	assign rounded_ext = ROOT_EXT_W'(rounded);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE, S_ROUND: begin
					if (accept) begin
						state_q <= arg_neg ? S_ROUND : S_RUN;
						cnt_q   <= '0;
					end else if (finish) begin
						state_q <= S_IDLE;
					end
				end
				S_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_STEP) begin
						state_q <= S_ROUND;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q <= arg_neg;
			up_q  <= round_up;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Drop the root on a negative argument.
	always_ff @(posedge clk) begin
		if (finish) begin
			root_q      <= neg_q ? '0 : rounded_ext[ROOT_OUT_W-1:0];
			neg_error_q <= neg_q;
		end
	end

	assign out_valid = out_valid_q;
	assign root      = root_q;
	assign neg_error = neg_error_q;

`ifndef SYNTHESIS
	a_neg_zero_root: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && neg_error |-> root == '0)
		else $error("negative argument gave a nonzero root");

	a_neg_skips_run: assert property (@(posedge clk) disable iff (!arst_n)
		accept && arg_neg |=> state_q == S_ROUND)
		else $error("negative argument entered the root steps");

	a_run_length: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RUN && cnt_q == LAST_STEP |=> state_q == S_ROUND && !in_ready ||
		state_q == S_ROUND && out_free)
		else $error("root steps did not end after the last digit");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RUN |-> !in_ready)
		else $error("item taken while root steps run");
`endif

endmodule

// ----- rtl/isqrt_shreg.sv -----
module isqrt_shreg
	import isqrt_pkg::*;
(
	input  logic             clk,
	input  ctrl_t            ctrl,
	input  logic [PAD_W-1:0] radicand,
	output logic [1:0]       pair
);

	logic [PAD_W-1:0] sh_q;

	// Load the radicand, then feed it out two bits at a time, high pair first.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			sh_q <= radicand;
		end else if (ctrl.step) begin
			sh_q <= {sh_q[PAD_W-3:0], 2'b00};
		end
	end

	assign pair = sh_q[PAD_W-1:PAD_W-2];

endmodule

// ----- rtl/isqrt_step.sv -----
module isqrt_step
	import isqrt_pkg::*;
(
	input  logic            clk,
	input  ctrl_t           ctrl,
	input  logic [1:0]      pair,
	output logic [HALF-1:0] root,
	output logic            rem_nz
);

	logic [REM_W-1:0]  rem_q;
	logic [HALF-1:0]   root_q;
	logic [WORK_W-1:0] work;
	logic [WORK_W-1:0] trial;
	logic [WORK_W-1:0] diff;
	logic              fits;

	// Bring down the next pair and try (4*root + 1) against it.
	assign work  = {rem_q, pair};
	assign trial = WORK_W'({root_q, 2'b01});
	assign diff  = work - trial;
	assign fits  = work >= trial;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			rem_q  <= '0;
			root_q <= '0;
		end else if (ctrl.step) begin
			rem_q  <= fits ? diff[REM_W-1:0] : work[REM_W-1:0];
			root_q <= {root_q[HALF-2:0], fits};
		end
	end

	assign root   = root_q;
	assign rem_nz = |rem_q;

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top
	import isqrt_pkg::*;
();

	localparam int CLK_HALF     = 6;
	localparam int RESET_CYCLES = 5;
	localparam int RANDOM_ITEMS = 1830;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int TAIL_CYCLES  = 40;
	localparam int HOLD_CYCLES  = 600;
	localparam int MAX_REPORTS  = 10;

	typedef struct {
		logic signed [N_W-1:0] arg;
		logic                  up;
		bit                    drain_first;
	} sqrt_req_t;

	typedef struct {
		logic [ROOT_OUT_W-1:0] root;
		logic                  neg_error;
	} sqrt_ans_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic signed [N_W-1:0] n = '0;
	logic                  round_up = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [ROOT_OUT_W-1:0] root;
	logic                  neg_error;

	sqrt_req_t pending_reqs[$];
	sqrt_ans_t roots_due[$];

	int cycle_count = 0;
	int hold_left = 0;
	int burst_left = 0;
	int gap_left = 0;
	int ready_mode = 0;
	int mode_left = 0;
	logic want_ready;
	int err_count = 0;
	int accepted_count = 0;
	int neg_count = 0;
	int up_count = 0;
	int checked_count = 0;

	integer_square_root_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.n        (n),
		.round_up (round_up),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.root     (root),
		.neg_error(neg_error)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Floor or ceiling square root, digit by digit, at the block's datapath width.
	function automatic sqrt_ans_t predict_root(logic signed [N_W-1:0] arg, logic up);
		logic [63:0] v;
		logic [63:0] rem;
		logic [63:0] res;
		logic [63:0] bitpos;
		sqrt_ans_t ans;
		v = {{(64 - N_W){arg[N_W-1]}}, arg};
		v &= ~64'd0 >> (64 - WIDTH);
		if (v[WIDTH-1]) begin
			ans.root = '0;
			ans.neg_error = 1'b1;
			return ans;
		end
		rem = v;
		res = '0;
		bitpos = 64'd1 << (WIDTH - 2);
		while (bitpos > rem)
			bitpos >>= 2;
		while (bitpos != 0) begin
			if (rem >= res + bitpos) begin
				rem -= res + bitpos;
				res = (res >> 1) + bitpos;
			end else begin
				res >>= 1;
			end
			bitpos >>= 2;
		end
		if (up && rem != 0)
			res++;
		ans.root = res[ROOT_OUT_W-1:0];
		ans.neg_error = 1'b0;
		return ans;
	endfunction

	function automatic sqrt_req_t random_req();
		sqrt_req_t req;
		int unsigned pick;
		longint r;
		longint sq;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			req.arg = $urandom_range(0, 1023);
		end else if (pick < 55) begin
			// land on, just below or just above a perfect square
			r = $urandom_range(0, 46340);
			sq = r * r + longint'($urandom_range(0, 2)) - 1;
			if (sq < 0)
				sq = 0;
			if (sq > 64'h7FFF_FFFF)
				sq = 64'h7FFF_FFFF;
			req.arg = sq[31:0];
		end else if (pick < 80) begin
			req.arg = $urandom;
		end else if (pick < 90) begin
			req.arg = {1'b0, 31'($urandom)} | 32'h4000_0000;
		end else begin
			req.arg = {1'b1, 31'($urandom)};
		end
		req.up = 1'($urandom_range(0, 1));
		req.drain_first = 1'b0;
		return req;
	endfunction

	task automatic queue_req(logic signed [N_W-1:0] arg, logic up, bit drain_first);
		sqrt_req_t req;
		req.arg = arg;
		req.up = up;
		req.drain_first = drain_first;
		pending_reqs.push_back(req);
	endtask

	task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
		err_count++;
		if (err_count <= MAX_REPORTS)
			$display("mismatch at cycle %0d: %s expected %0d got %0d", cycle_count, what,
				want, got);
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d roots still due", cycle_count,
				roots_due.size());
			$display("tb_top: done, errors");
			$finish;
		end
	end

	// Long receiver hold-offs while the sender keeps offering items.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (cycle_count == 3000 || cycle_count == 18000) begin
			hold_left <= HOLD_CYCLES;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			ready_mode = 0;
			mode_left = 0;
		end else begin
			if (mode_left == 0) begin
				ready_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(64, 512);
			end else begin
				mode_left--;
			end
			case (ready_mode)
				0: want_ready = 1'b1;
				1: want_ready = 1'($urandom_range(0, 1));
				2: want_ready = ($urandom_range(0, 3) == 0);
				default: want_ready = (cycle_count % 7) < 4;
			endcase
			out_ready <= (hold_left == 0) && want_ready;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			n <= '0;
			round_up <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (in_valid && in_ready) begin
				roots_due.push_back(predict_root(n, round_up));
				accepted_count++;
				if (n[N_W-1])
					neg_count++;
				if (round_up)
					up_count++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_reqs.size() != 0 &&
					!(pending_reqs[0].drain_first && roots_due.size() != 0)) begin
					n <= pending_reqs[0].arg;
					round_up <= pending_reqs[0].up;
					in_valid <= 1'b1;
					void'(pending_reqs.pop_front());
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (roots_due.size() == 0) begin
				note_mismatch("result with no item pending, root", 0, 32'(root));
			end else begin
				if (root !== roots_due[0].root)
					note_mismatch("root", 32'(roots_due[0].root), 32'(root));
				if (neg_error !== roots_due[0].neg_error)
					note_mismatch("neg_error", 32'(roots_due[0].neg_error), 32'(neg_error));
				void'(roots_due.pop_front());
				checked_count++;
			end
		end
	end

	initial begin
		// zero, small values and round-up on both sides of perfect squares
		queue_req(32'sd0, 1'b0, 1'b0);
		queue_req(32'sd0, 1'b1, 1'b0);
		queue_req(32'sd1, 1'b0, 1'b0);
		queue_req(32'sd1, 1'b1, 1'b0);
		queue_req(32'sd2, 1'b0, 1'b0);
		queue_req(32'sd2, 1'b1, 1'b0);
		queue_req(32'sd3, 1'b1, 1'b0);
		queue_req(32'sd4, 1'b1, 1'b0);
		queue_req(32'sd15, 1'b0, 1'b0);
		queue_req(32'sd16, 1'b1, 1'b0);
		queue_req(32'sd17, 1'b1, 1'b0);
		// marker starts right at the top bit
		queue_req(32'sh4000_0000, 1'b0, 1'b1);
		queue_req(32'sh3FFF_FFFF, 1'b1, 1'b0);
		queue_req(32'sd2147395600, 1'b1, 1'b0);
		queue_req(32'sd2147395601, 1'b1, 1'b0);
		queue_req(32'sh7FFF_FFFF, 1'b0, 1'b0);
		queue_req(32'sh7FFF_FFFF, 1'b1, 1'b0);
		// negative arguments, then one positive alternating pattern
		queue_req(32'sh8000_0000, 1'b0, 1'b0);
		queue_req(32'sh8000_0000, 1'b1, 1'b0);
		queue_req(-32'sd1, 1'b0, 1'b0);
		queue_req(-32'sd1, 1'b1, 1'b0);
		queue_req(32'shAAAA_5555, 1'b1, 1'b0);
		queue_req(32'sh5555_AAAA, 1'b0, 1'b0);
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			pending_reqs.push_back(random_req());
			// pause the sender until every root has come back
			if (i == 600 || i == 1300)
				pending_reqs[$].drain_first = 1'b1;
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_reqs.size() != 0 || in_valid)
			@(negedge clk);
		while (roots_due.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("tb_top: %0d items sent (%0d negative, %0d with round_up), %0d roots checked",
			accepted_count, neg_count, up_count, checked_count);
		$display("tb_top: %0d mismatches in %0d cycles", err_count, cycle_count);
		if (err_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
